[hdl/obb_pkg.sv]
// shared types, constants and helpers for the overlapping block blend raster
`default_nettype none

package obb_pkg;

  localparam int BLOCK_SLOTS = 8;
  localparam int COORD_BITS  = 12;
  localparam int DIM_BITS    = COORD_BITS + 1;
  localparam int SLOT_BITS   = 3;
  localparam int CNT_BITS    = 4;
  localparam int CHANNELS    = 3;
  localparam int PROD_BITS   = 16;
  localparam int SUM_BITS    = 20;
  localparam int QUO_BITS    = 11;
  localparam int RECIP_BITS  = 17;
  localparam int RECIP_SHIFT = 16;

  // floor(2^23 / 255), always at or below the true quotient
  localparam logic [15:0] INV255       = 16'd32896;
  localparam int          INV255_SHIFT = 23;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_DEFAULT_COLOR,
    REG_BLOCK_COUNT
  } cfg_reg_e;

  typedef struct packed {
    logic                  opcode;
    logic [SLOT_BITS-1:0]  block_slot;
    logic [COORD_BITS-1:0] block_left;
    logic [COORD_BITS-1:0] block_top;
    logic [COORD_BITS-1:0] block_width;
    logic [COORD_BITS-1:0] block_height;
    logic [31:0]           block_color;
  } in_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       covered;
    logic       end_of_frame;
    logic       rejected;
  } out_t;

  typedef struct packed {
    logic                  valid;
    logic                  rejected;
    logic                  end_of_frame;
    logic                  covered;
    logic [7:0]            alpha;
  } side_t;

  // ceil(2^16 / cnt); exact quotient for values below 2^11
  function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] cnt);
    logic [RECIP_BITS-1:0] r;
    unique case (cnt)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/obb_div.sv]
// three stage divide of the weighted channel sums by 255 times the cover count
`default_nettype none

module obb_div import obb_pkg::*; (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic [CHANNELS-1:0][SUM_BITS-1:0] sum,
  input  logic [CNT_BITS-1:0]               cnt,
  input  side_t                             side,
  output logic [CHANNELS-1:0][7:0]          quot,
  output side_t                             side_out
);

  logic [CHANNELS-1:0][SUM_BITS-1:0] e_sum;
  logic [CHANNELS-1:0][QUO_BITS-1:0] e_q0;
  logic [CNT_BITS-1:0]               e_cnt;
  side_t                             e_side;

  logic [CHANNELS-1:0][QUO_BITS-1:0] f_q;
  logic [CNT_BITS-1:0]               f_cnt;
  side_t                             f_side;

  logic [CHANNELS-1:0][QUO_BITS-1:0] q0_next;
  logic [CHANNELS-1:0][QUO_BITS-1:0] q_next;
  logic [CHANNELS-1:0][7:0]          quot_next;

  always_comb begin
    logic [SUM_BITS+15:0]             p;
    logic [SUM_BITS-1:0]              rem;
    logic [QUO_BITS+RECIP_BITS-1:0]   p2;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      // reciprocal estimate, low by at most one
      p = (SUM_BITS+16)'(sum[ch]) * (SUM_BITS+16)'(INV255);
      q0_next[ch] = QUO_BITS'(p >> INV255_SHIFT);
      rem = e_sum[ch] - (SUM_BITS'({e_q0[ch], 8'd0}) - SUM_BITS'(e_q0[ch]));
      q_next[ch] = e_q0[ch] + QUO_BITS'(rem >= SUM_BITS'(255));
      p2 = (QUO_BITS+RECIP_BITS)'(f_q[ch]) * (QUO_BITS+RECIP_BITS)'(recip(f_cnt));
      quot_next[ch] = 8'(p2 >> RECIP_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_side.valid   <= 1'b0;
      f_side.valid   <= 1'b0;
      side_out.valid <= 1'b0;
    end else if (en) begin
      e_sum    <= sum;
      e_q0     <= q0_next;
      e_cnt    <= cnt;
      e_side   <= side;
      f_q      <= q_next;
      f_cnt    <= e_cnt;
      f_side   <= e_side;
      quot     <= quot_next;
      side_out <= f_side;
    end
  end

endmodule

`default_nettype wire

[hdl/overlapping_block_blend.sv]
// top level of the overlapping block blend raster
`default_nettype none

// Load items write one of eight block slots; render items walk the image row by
// row and give one BGRA pixel each, blended over the covering blocks. The block
// takes one item per clock while the pixel output does not stall: a seven stage
// pipeline (position, cover test, products, sums, divide in three steps). When
// the pixel output stalls the whole pipeline holds, so item_stall follows
// pixel_stall while a pixel is waiting. The user is to write configuration only
// while the block is idle; the block does not enforce it and cfg_ready is always
// high. Block slots have no reset and must be loaded before a render uses them.
module overlapping_block_blend import obb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  in_t         item,
  output logic        pixel_valid,
  input  logic        pixel_stall,
  output out_t        pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef struct packed {
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] top;
    logic [DIM_BITS-1:0]   right;
    logic [DIM_BITS-1:0]   bottom;
  } bounds_t;

  logic [DIM_BITS-1:0] image_width;
  logic [DIM_BITS-1:0] image_height;
  logic [31:0]         default_color;
  logic [CNT_BITS-1:0] block_count;

  bounds_t     block_bounds [BLOCK_SLOTS];
  logic [31:0] block_colors [BLOCK_SLOTS];

  logic [COORD_BITS-1:0] row;
  logic [COORD_BITS-1:0] col;

  logic en, item_acc, render, reject_now, col_wrap, row_wrap;
  logic [COORD_BITS-1:0] last_col, last_row;
  logic [CNT_BITS-1:0]   slots_used;

  assign en         = !(pixel_valid && pixel_stall);
  assign item_stall = !en;
  assign item_acc   = item_valid && !item_stall;
  assign render     = item_acc && item.opcode == OP_RENDER;
  assign cfg_ready  = 1'b1;
  assign reject_now = block_count == '0;

  always_comb begin
    if (image_width == '0) last_col = '0;
    else if (image_width > DIM_BITS'(1 << COORD_BITS)) last_col = '1;
    else last_col = COORD_BITS'(image_width - DIM_BITS'(1));
    if (image_height == '0) last_row = '0;
    else if (image_height > DIM_BITS'(1 << COORD_BITS)) last_row = '1;
    else last_row = COORD_BITS'(image_height - DIM_BITS'(1));
    slots_used = (block_count > CNT_BITS'(BLOCK_SLOTS)) ? CNT_BITS'(BLOCK_SLOTS) : block_count;
  end

  assign col_wrap = col >= last_col;
  assign row_wrap = row >= last_row;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= DIM_BITS'(1);
      image_height  <= DIM_BITS'(1);
      default_color <= '0;
      block_count   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[DIM_BITS-1:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data[DIM_BITS-1:0];
        REG_DEFAULT_COLOR: default_color <= cfg_data;
        REG_BLOCK_COUNT:   block_count   <= cfg_data[CNT_BITS-1:0];
      endcase
    end
  end

  // block table
  always_ff @(posedge clk) begin
    if (item_acc && item.opcode == OP_LOAD) begin
      block_bounds[item.block_slot].left   <= item.block_left;
      block_bounds[item.block_slot].top    <= item.block_top;
      block_bounds[item.block_slot].right  <= DIM_BITS'(item.block_left) +
                                              DIM_BITS'(item.block_width);
      block_bounds[item.block_slot].bottom <= DIM_BITS'(item.block_top) +
                                              DIM_BITS'(item.block_height);
      block_colors[item.block_slot]        <= item.block_color;
    end
  end

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (render && !reject_now) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row + COORD_BITS'(1);
      end else begin
        col <= col + COORD_BITS'(1);
      end
    end
  end

  // stage a: pixel position
  logic                  a_valid, a_rej, a_eof;
  logic [COORD_BITS-1:0] a_row, a_col;

  // stage b: cover test
  logic                     b_valid, b_rej, b_eof;
  logic [BLOCK_SLOTS-1:0]   b_hit;
  logic [31:0]              b_color [BLOCK_SLOTS];

  // stage c: colour times alpha
  logic                     c_valid, c_rej, c_eof;
  logic [BLOCK_SLOTS-1:0]   c_hit;
  logic [CHANNELS-1:0][PROD_BITS-1:0] c_prod [BLOCK_SLOTS];
  logic [7:0]               c_alpha [BLOCK_SLOTS];

  // stage d: sums, count, max alpha
  logic [CHANNELS-1:0][SUM_BITS-1:0] d_sum;
  logic [CNT_BITS-1:0]               d_cnt;
  side_t                             d_side;

  logic [BLOCK_SLOTS-1:0] hit_next;
  logic [CHANNELS-1:0][SUM_BITS-1:0] sum_next;
  logic [CNT_BITS-1:0]   cnt_next;
  logic [7:0]            amax_next;

  always_comb begin
    for (int i = 0; i < BLOCK_SLOTS; i++) begin
      hit_next[i] = CNT_BITS'(i) < slots_used &&
                    DIM_BITS'(a_row) >= DIM_BITS'(block_bounds[i].top) &&
                    DIM_BITS'(a_row) <= block_bounds[i].bottom &&
                    DIM_BITS'(a_col) >= DIM_BITS'(block_bounds[i].left) &&
                    DIM_BITS'(a_col) <= block_bounds[i].right;
    end
    sum_next  = '0;
    amax_next = '0;
    for (int i = 0; i < BLOCK_SLOTS; i++) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        sum_next[ch] = sum_next[ch] + SUM_BITS'(c_prod[i][ch]);
      end
      if (c_alpha[i] > amax_next) amax_next = c_alpha[i];
    end
    cnt_next = CNT_BITS'($countones(c_hit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      c_valid      <= 1'b0;
      d_side.valid <= 1'b0;
    end else if (en) begin
      a_valid <= render;
      a_rej   <= reject_now;
      a_eof   <= col_wrap && row_wrap && !reject_now;
      a_row   <= row;
      a_col   <= col;

      b_valid <= a_valid;
      b_rej   <= a_rej;
      b_eof   <= a_eof;
      b_hit   <= hit_next;
      for (int i = 0; i < BLOCK_SLOTS; i++) begin
        b_color[i] <= hit_next[i] ? block_colors[i] : 32'd0;
      end

      c_valid <= b_valid;
      c_rej   <= b_rej;
      c_eof   <= b_eof;
      c_hit   <= b_hit;
      for (int i = 0; i < BLOCK_SLOTS; i++) begin
        // channel 0 blue, 1 green, 2 red
        for (int ch = 0; ch < CHANNELS; ch++) begin
          c_prod[i][ch] <= PROD_BITS'(b_color[i][31-8*ch -: 8]) *
                           PROD_BITS'(b_color[i][7:0]);
        end
        c_alpha[i] <= b_color[i][7:0];
      end

      d_sum               <= sum_next;
      d_cnt               <= cnt_next;
      d_side.valid        <= c_valid;
      d_side.rejected     <= c_rej;
      d_side.end_of_frame <= c_eof;
      d_side.covered      <= cnt_next != '0;
      d_side.alpha        <= amax_next;
    end
  end

  logic [CHANNELS-1:0][7:0] g_quot;
  side_t                    g_side;

  obb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .sum      (d_sum),
    .cnt      (d_cnt),
    .side     (d_side),
    .quot     (g_quot),
    .side_out (g_side)
  );

  assign pixel_valid = g_side.valid;

  always_comb begin
    pixel = '0;
    if (g_side.rejected) begin
      pixel.rejected = 1'b1;
    end else if (g_side.covered) begin
      pixel.blue         = g_quot[0];
      pixel.green        = g_quot[1];
      pixel.red          = g_quot[2];
      pixel.alpha        = g_side.alpha;
      pixel.covered      = 1'b1;
      pixel.end_of_frame = g_side.end_of_frame;
    end else begin
      pixel.blue         = default_color[31:24];
      pixel.green        = default_color[23:16];
      pixel.red          = default_color[15:8];
      pixel.alpha        = default_color[7:0];
      pixel.end_of_frame = g_side.end_of_frame;
    end
  end

`ifndef SYNTHESIS
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel.rejected |-> pixel.blue == 8'd0 && pixel.green == 8'd0 &&
      pixel.red == 8'd0 && pixel.alpha == 8'd0 && !pixel.covered && !pixel.end_of_frame)
    else $error("rejected pixel carries nonzero fields");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> $stable(d_sum) && $stable(b_valid) && $stable(a_row))
    else $error("pipeline moved during output stall");

  a_load_keeps_pos: assert property (@(posedge clk) disable iff (rst)
    item_acc && item.opcode == OP_LOAD |=> $stable(row) && $stable(col))
    else $error("load transfer moved the raster position");
`endif

endmodule

`default_nettype wire

[sim/overlapping_block_blend_test.sv]
// self-checking testbench for the overlapping block blend raster
`default_nettype none

module overlapping_block_blend_test;
  timeunit 1ns;
  timeprecision 1ps;
  import obb_pkg::*;

  localparam int PIPE_LATENCY = 7;
  localparam int HOLD_CYCLES  = 80;
  localparam int MAX_GAP      = 17;
  localparam int PHASES       = 22;
  localparam int PHASE_ITEMS  = 50;
  localparam int PRINT_CAP    = 50;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  in_t         item = '0;
  logic        pixel_valid;
  logic        pixel_stall = 1'b0;
  out_t        pixel;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  overlapping_block_blend dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel      (pixel),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // shadow of the block: table, registers and raster position
  logic [COORD_BITS-1:0] slot_left   [BLOCK_SLOTS];
  logic [COORD_BITS-1:0] slot_top    [BLOCK_SLOTS];
  logic [COORD_BITS:0]   slot_right  [BLOCK_SLOTS];
  logic [COORD_BITS:0]   slot_bottom [BLOCK_SLOTS];
  logic [31:0]           slot_color  [BLOCK_SLOTS];
  logic [12:0]           reg_width   = 13'd1;
  logic [12:0]           reg_height  = 13'd1;
  logic [31:0]           reg_default = '0;
  logic [3:0]            reg_count   = '0;
  logic [COORD_BITS-1:0] raster_row  = '0;
  logic [COORD_BITS-1:0] raster_col  = '0;

  out_t pixel_expect[$];

  int error_count   = 0;
  int pixels_seen   = 0;
  int renders_sent  = 0;
  int loads_sent    = 0;
  int frame_ends    = 0;
  int cfg_writes    = 0;
  int hold_requests = 0;
  int holds_done    = 0;
  int stall_left    = 0;
  bit tx_no_gap     = 1'b0;

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_CAP) $display("mismatch: %s", what);
    error_count++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("pixel %0d %s got %0d want %0d", pixels_seen, name, got, want));
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic int clamp_dim(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > (1 << COORD_BITS)) return 1 << COORD_BITS;
    return v;
  endfunction

  // update the shadow state for one accepted item and queue a render's pixel
  task automatic predict_item(input in_t it);
    int   n, w, h, r, c, cnt, max_a, sum_b, sum_g, sum_r, a, d;
    out_t px;
    if (it.opcode == OP_LOAD) begin
      slot_left[it.block_slot]   = it.block_left;
      slot_top[it.block_slot]    = it.block_top;
      slot_right[it.block_slot]  = {1'b0, it.block_left} + {1'b0, it.block_width};
      slot_bottom[it.block_slot] = {1'b0, it.block_top} + {1'b0, it.block_height};
      slot_color[it.block_slot]  = it.block_color;
      loads_sent++;
      return;
    end
    renders_sent++;
    px = '0;
    if (reg_count == 0) begin
      // rejected: position holds, everything else zero
      px.rejected = 1'b1;
      pixel_expect.push_back(px);
      return;
    end
    n = (reg_count > BLOCK_SLOTS) ? BLOCK_SLOTS : reg_count;
    w = clamp_dim(reg_width);
    h = clamp_dim(reg_height);
    r = raster_row;
    c = raster_col;
    cnt = 0;
    max_a = 0;
    sum_b = 0;
    sum_g = 0;
    sum_r = 0;
    for (int i = 0; i < n; i++) begin
      if (r < slot_top[i] || r > slot_bottom[i] || c < slot_left[i] || c > slot_right[i])
        continue;
      a = slot_color[i][7:0];
      sum_b += int'(slot_color[i][31:24]) * a;
      sum_g += int'(slot_color[i][23:16]) * a;
      sum_r += int'(slot_color[i][15:8]) * a;
      if (a > max_a) max_a = a;
      cnt++;
    end
    if (cnt > 0) begin
      d = 255 * cnt;
      px.blue    = 8'(sum_b / d);
      px.green   = 8'(sum_g / d);
      px.red     = 8'(sum_r / d);
      px.alpha   = 8'(max_a);
      px.covered = 1'b1;
    end else begin
      px.blue  = reg_default[31:24];
      px.green = reg_default[23:16];
      px.red   = reg_default[15:8];
      px.alpha = reg_default[7:0];
    end
    // a position left outside a shrunk image still wraps on this pixel
    if (c >= w - 1) begin
      raster_col = '0;
      if (r >= h - 1) begin
        raster_row = '0;
        px.end_of_frame = 1'b1;
        frame_ends++;
      end else begin
        raster_row = COORD_BITS'(r + 1);
      end
    end else begin
      raster_col = COORD_BITS'(c + 1);
    end
    pixel_expect.push_back(px);
  endtask

  // valid stays high after a transfer; the next call lowers it only for a gap
  task automatic send_item(input in_t it);
    int gap;
    gap = tx_no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_item(it);
  endtask

  task automatic set_reg(input cfg_reg_e idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:   reg_width   = data[12:0];
      REG_IMAGE_HEIGHT:  reg_height  = data[12:0];
      REG_DEFAULT_COLOR: reg_default = data;
      REG_BLOCK_COUNT:   reg_count   = data[3:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // unused upper data bits carry noise; the block keeps only the low bits
  task automatic apply_config(input int w, input int h, input logic [31:0] dflt, input int cnt);
    set_reg(REG_IMAGE_WIDTH,   {19'($urandom_range(0, 32'h7ffff)), w[12:0]});
    set_reg(REG_IMAGE_HEIGHT,  {19'($urandom_range(0, 32'h7ffff)), h[12:0]});
    set_reg(REG_DEFAULT_COLOR, dflt);
    set_reg(REG_BLOCK_COUNT,   {28'($urandom_range(0, 32'hfffffff)), cnt[3:0]});
    cfg_valid <= 1'b0;
  endtask

  // load items give no pixel, so allow the pipeline to empty after the last one
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pixel_expect.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  function automatic in_t load_item(input int slot, input int l, input int t,
                                    input int w, input int h, input logic [31:0] col);
    in_t it;
    it.opcode       = OP_LOAD;
    it.block_slot   = SLOT_BITS'(slot);
    it.block_left   = COORD_BITS'(l);
    it.block_top    = COORD_BITS'(t);
    it.block_width  = COORD_BITS'(w);
    it.block_height = COORD_BITS'(h);
    it.block_color  = col;
    return it;
  endfunction

  // render items carry random block fields, which the block must ignore
  function automatic in_t render_item();
    in_t it;
    it = load_item($urandom_range(0, 7), $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
    it.opcode = OP_RENDER;
    return it;
  endfunction

  function automatic int pick_coord();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 4095);
    return $urandom_range(0, 7);
  endfunction

  function automatic in_t random_item();
    in_t it;
    it = load_item($urandom_range(0, 7), pick_coord(), pick_coord(), pick_coord(),
                   pick_coord(), $urandom);
    if ($urandom_range(0, 99) < 65) it.opcode = OP_RENDER;
    return it;
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1 << COORD_BITS;
      2:       return $urandom_range(0, 8191);
      3:       return 1;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic int pick_count();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return $urandom_range(BLOCK_SLOTS + 1, 15);
      default: return $urandom_range(1, BLOCK_SLOTS);
    endcase
  endfunction

  task automatic test_rejected_at_reset();
    send_item(render_item());
    send_item(render_item());
    wait_idle();
  endtask

  // every slot is loaded here, so no later render reads an unwritten slot
  task automatic test_table_extremes();
    send_item(load_item(0, 0, 0, 0, 0, 32'hffffffff));
    send_item(load_item(1, 0, 0, 4095, 4095, 32'h00000000));
    send_item(load_item(2, 4095, 4095, 4095, 4095, 32'h123456ff));
    send_item(load_item(3, 1, 0, 1, 1, 32'hff00ff80));
    for (int s = 4; s < BLOCK_SLOTS; s++)
      send_item(load_item(s, $urandom_range(0, 3), $urandom_range(0, 3),
                          $urandom_range(0, 3), $urandom_range(0, 3), $urandom));
    wait_idle();
  endtask

  // zero width acts as one, oversize count saturates; both frames end exactly
  task automatic test_small_frames();
    apply_config(0, 3, 32'ha5a5a5a5, 15);
    repeat (3) send_item(render_item());
    wait_idle();
    apply_config(3, 2, 32'h5a5a5a5a, 2);
    repeat (6) send_item(render_item());
    wait_idle();
  endtask

  task automatic test_position_past_image();
    apply_config(8191, 4097, 32'h00ff00ff, BLOCK_SLOTS);
    repeat (4) send_item(render_item());
    wait_idle();
    apply_config(2, 2, 32'hffffff00, 4);
    repeat (3) send_item(render_item());
    wait_idle();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) apply_config(1 << COORD_BITS, 1 << COORD_BITS, 32'hffffffff, BLOCK_SLOTS);
      else if (p == 1) apply_config(1, 1, 32'h00000000, 1);
      else apply_config(pick_dim(), pick_dim(), $urandom, pick_count());
      repeat (PHASE_ITEMS) send_item(random_item());
      wait_idle();
    end
  endtask

  // receiver holds off while items keep coming, so the pipeline backs up
  task automatic test_output_backpressure();
    apply_config(5, 4, $urandom, BLOCK_SLOTS);
    tx_no_gap = 1'b1;
    hold_requests++;
    repeat (60) send_item(render_item());
    tx_no_gap = 1'b0;
    wait_idle();
  endtask

  // pixel receiver: checks each transfer and draws its own stalls
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      pixel_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        pixels_seen++;
        if (pixel_expect.size() == 0) begin
          report_mismatch($sformatf("pixel %0d arrived with none expected", pixels_seen));
        end else begin
          want = pixel_expect.pop_front();
          compare_field("blue", pixel.blue, want.blue);
          compare_field("green", pixel.green, want.green);
          compare_field("red", pixel.red, want.red);
          compare_field("alpha", pixel.alpha, want.alpha);
          compare_field("covered", pixel.covered, want.covered);
          compare_field("end_of_frame", pixel.end_of_frame, want.end_of_frame);
          compare_field("rejected", pixel.rejected, want.rejected);
        end
      end
      if (holds_done != hold_requests) begin
        holds_done++;
        stall_left = HOLD_CYCLES;
      end else if (pixel_valid && !pixel_stall) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        pixel_stall <= 1'b1;
        stall_left--;
      end else begin
        pixel_stall <= 1'b0;
      end
    end
  end

  initial begin
    #2000000;
    $display("overlapping_block_blend test failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_rejected_at_reset();
    test_table_extremes();
    test_small_frames();
    test_position_past_image();
    test_random_phases();
    test_output_backpressure();
    wait_idle();
    if (pixel_expect.size() != 0)
      report_mismatch($sformatf("%0d pixels never arrived", pixel_expect.size()));
    $display("run: %0d renders and %0d block loads, %0d pixels checked",
             renders_sent, loads_sent, pixels_seen);
    $display("run: %0d frame ends, %0d register writes, %0d mismatches",
             frame_ends, cfg_writes, error_count);
    if (error_count == 0) begin
      $display("overlapping_block_blend test passed");
    end else begin
      $display("overlapping_block_blend test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
